### sv/i460_pkg.sv
// ----------------------------------------------------------------------------
// i460_pkg
// Shared types, rate codes and helpers for the I.460 sub-rate demultiplexer.
// ----------------------------------------------------------------------------
package i460_pkg;

    // fixed number of sub-channel lanes carried in a result record
    localparam int NUM_LANES   = 8;
    localparam int LANE_W      = 3;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // rate codes
    localparam logic [2:0] RATE_NONE = 3'd0;
    localparam logic [2:0] RATE_8K   = 3'd1;
    localparam logic [2:0] RATE_16K  = 3'd2;
    localparam logic [2:0] RATE_32K  = 3'd3;
    localparam logic [2:0] RATE_64K  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_RATES   = 2'd0;
    localparam logic [1:0] CFG_OFFSETS = 2'd1;
    localparam logic [1:0] CFG_FRAMES  = 2'd2;

    // completed bytes caused by one slot byte, one lane per sub-channel
    typedef struct packed {
        logic [NUM_LANES-1:0]        mask;
        logic [NUM_LANES-1:0]        fend;
        logic [NUM_LANES-1:0][7:0]   data;
    } record_t;

    // queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // bits taken from each slot byte at a given rate
    function automatic logic [3:0] bits_of_rate(input logic [2:0] rate);
        logic [3:0] nbits;
        case (rate)
            RATE_8K:  nbits = 4'd1;
            RATE_16K: nbits = 4'd2;
            RATE_32K: nbits = 4'd4;
            RATE_64K: nbits = 4'd8;
            default:  nbits = 4'd0;
        endcase
        return nbits;
    endfunction

endpackage

### sv/i460_front.sv
// ----------------------------------------------------------------------------
// i460_front
// Accepts slot bytes, updates every sub-channel's partial byte and frame
// position together and queues a record of the bytes that completed.
// ----------------------------------------------------------------------------
module i460_front #(
    parameter int NUM_SUBCHANNELS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             slot_byte,
    input  logic [23:0]            rates,
    input  logic [23:0]            offsets,
    input  logic [63:0]            frames,
    input  i460_pkg::q_status_t    q_status,
    output logic                   push,
    output i460_pkg::record_t      rec
);
    import i460_pkg::*;

    logic                 accept;
    logic [NUM_LANES-1:0] enabled;
    logic                 passthru;

    // request accepted whenever the queue has room
    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    // single sub-channel 0 at 64k passes the byte straight through
    assign passthru = ($countones(enabled) == 1) && (rates[2:0] == RATE_64K);

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        if (i < NUM_SUBCHANNELS) begin : g_used
            logic [7:0]  partial_reg;
            logic [7:0]  partial_next;
            logic [10:0] pos_reg;
            logic [10:0] pos_next;
            logic [2:0]  rate;
            logic [2:0]  off;
            logic [7:0]  flen;
            logic [3:0]  nbits;
            logic [7:0]  bits;
            logic [15:0] win;
            logic [15:0] win_shift;
            logic [2:0]  cnt;
            logic [3:0]  fill;
            logic [3:0]  spill;
            logic        done;
            logic [8:0]  len;
            logic [8:0]  pbytes;
            logic        fend;
            logic        hit;
            logic [7:0]  data;

            assign rate      = rates[3*i +: 3];
            assign off       = offsets[3*i +: 3];
            assign flen      = frames[8*i +: 8];
            assign nbits     = bits_of_rate(rate);
            assign enabled[i] = (nbits != 4'd0);
            assign bits      = slot_byte << off;
            assign win       = {partial_reg, bits};
            assign win_shift = win << nbits;
            assign cnt       = pos_reg[2:0];
            assign fill      = {1'b0, cnt} + nbits;
            assign spill     = fill - 4'd8;
            assign done      = fill[3];
            assign len       = (flen == 8'd0) ? 9'd256 : {1'b0, flen};
            assign pbytes    = {1'b0, pos_reg[10:3]} + 9'd1;
            assign fend      = (pbytes >= len);

            // lane update: shift in new bits, emit on byte boundary
            always_comb
            begin
                partial_next = win_shift[15:8];
                data         = win[cnt +: 8];
                hit          = done;
                if (done)
                begin
                    if (fend)
                        pos_next = {8'd0, spill[2:0]};
                    else
                        pos_next = {pbytes[7:0], spill[2:0]};
                end
                else
                begin
                    pos_next = pos_reg + {7'd0, nbits};
                end
                if (passthru && (i == 0))
                begin
                    partial_next = partial_reg;
                    data         = slot_byte;
                    hit          = 1'b1;
                    pos_next     = fend ? 11'd0 : (pos_reg + 11'd8);
                end
            end

            // per sub-channel state
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    partial_reg <= 8'd0;
                    pos_reg     <= 11'd0;
                end
                else if (accept)
                begin
                    partial_reg <= partial_next;
                    pos_reg     <= pos_next;
                end
            end

            assign rec.mask[i] = hit;
            assign rec.fend[i] = fend;
            assign rec.data[i] = data;
        end
        else begin : g_unused
            assign enabled[i]  = 1'b0;
            assign rec.mask[i] = 1'b0;
            assign rec.fend[i] = 1'b0;
            assign rec.data[i] = 8'd0;
        end
    end

    // only records with at least one completed byte are queued
    assign push = accept && (rec.mask != '0);

    // a byte with every sub-channel disabled produces nothing
    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (enabled == '0)) |-> !push)
        else $error("record queued with no enabled sub-channel");

endmodule

### sv/i460_queue.sv
// ----------------------------------------------------------------------------
// i460_queue
// Short register queue of result records between front and back.
// ----------------------------------------------------------------------------
module i460_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  i460_pkg::record_t    push_rec,
    input  logic                 pop,
    output i460_pkg::record_t    head,
    output i460_pkg::q_status_t  status
);
    import i460_pkg::*;

    record_t             rec_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign status.full  = (count_reg == QUEUE_DEPTH[QPTR_W:0]);
    assign status.empty = (count_reg == '0);
    assign head         = rec_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (push)
            rec_reg[wr_ptr_reg] <= push_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_DEPTH[QPTR_W:0])
        else $error("queue count beyond depth");

endmodule

### sv/i460_back.sv
// ----------------------------------------------------------------------------
// i460_back
// Takes queued records and hands out their completed bytes one a cycle
// while out_stall is low, lowest sub-channel first, through an output register.
// ----------------------------------------------------------------------------
module i460_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  i460_pkg::q_status_t  q_status,
    input  i460_pkg::record_t    head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           subchannel_index,
    output logic [7:0]           data_byte,
    output logic                 frame_end,
    output logic                 last_of_input
);
    import i460_pkg::*;

    record_t              cur_reg;
    logic [NUM_LANES-1:0] mask_reg;
    logic [NUM_LANES-1:0] mask_next;
    logic [NUM_LANES-1:0] rem;
    logic [LANE_W-1:0]    sel;
    logic                 have;
    logic                 slot_free;
    logic                 emit;
    logic                 out_valid_reg;
    logic [2:0]           index_reg;
    logic [7:0]           data_reg;
    logic                 fend_reg;
    logic                 last_reg;

    // lowest pending sub-channel
    always_comb
    begin
        sel = '0;
        for (int k = NUM_LANES - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
                sel = LANE_W'(k);
        end
    end

    assign have      = (mask_reg != '0);
    assign rem       = mask_reg & (mask_reg - 1'b1);
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = slot_free && have;
    assign pop       = !q_status.empty && (!have || (emit && (rem == '0)));

    // pending mask of the current record
    always_comb
    begin
        if (pop)
            mask_next = head.mask;
        else if (emit)
            mask_next = rem;
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (slot_free)
                out_valid_reg <= 1'b0;
        end
    end

    // record payload and output fields
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (emit)
        begin
            index_reg <= sel;
            data_reg  <= cur_reg.data[sel];
            fend_reg  <= cur_reg.fend[sel];
            last_reg  <= (rem == '0);
        end
    end

    assign out_valid        = out_valid_reg;
    assign subchannel_index = index_reg;
    assign data_byte        = data_reg;
    assign frame_end        = fend_reg;
    assign last_of_input    = last_reg;

    a_pop_nonempty_rec: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (head.mask != '0))
        else $error("empty record taken from queue");

    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (rem != '0)) |=> have)
        else $error("pending bytes lost after emit");

endmodule

### sv/i460_subrate_demultiplexer_unit.sv
// ----------------------------------------------------------------------------
// i460_subrate_demultiplexer_unit
// I.460 sub-rate demultiplexer: splits timeslot bytes into up to eight
// sub-channels and emits each completed sub-channel byte.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_stall  | slot_byte
// out      | output    | out_valid/out_stall  | subchannel_index, data_byte,
//          |           |                      | frame_end, last_of_input
// cfg      | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one slot byte is taken every cycle while the four-entry record queue has room
// each request yields 0 to 8 results, delivered one a cycle by the back end while out_stall is low
// results pass through the record queue, the back end's pending mask and the output register
// rst_n clears sub-channel state, config, queue pointers and valid/mask registers; no clearing pass
// out_stall holds the output register, then the queue fills, then in_stall rises
// ----------------------------------------------------------------------------
module i460_subrate_demultiplexer_unit #(
    parameter int NUM_SUBCHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  slot_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  subchannel_index,
    output logic [7:0]  data_byte,
    output logic        frame_end,
    output logic        last_of_input,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import i460_pkg::*;

    logic [23:0] rates_reg;
    logic [23:0] offsets_reg;
    logic [63:0] frames_reg;
    q_status_t   q_status;
    record_t     push_rec;
    record_t     head;
    logic        push;
    logic        pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rates_reg   <= '0;
            offsets_reg <= '0;
            frames_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RATES:   rates_reg   <= cfg_data[23:0];
                CFG_OFFSETS: offsets_reg <= cfg_data[23:0];
                CFG_FRAMES:  frames_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // bit extraction and byte assembly
    i460_front #(
        .NUM_SUBCHANNELS(NUM_SUBCHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .slot_byte (slot_byte),
        .rates     (rates_reg),
        .offsets   (offsets_reg),
        .frames    (frames_reg),
        .q_status  (q_status),
        .push      (push),
        .rec       (push_rec)
    );

    // record queue
    i460_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // result serialiser
    i460_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_status         (q_status),
        .head             (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .subchannel_index (subchannel_index),
        .data_byte        (data_byte),
        .frame_end        (frame_end),
        .last_of_input    (last_of_input)
    );

endmodule
